// ===== src/sawc_pkg.sv =====
`timescale 1ns / 1ps
package sawc_pkg;

    localparam int MAX_STEPS = 16;
    localparam int MAX_DIM   = 2;
    localparam int COUNT_W   = 32;
    localparam int STEPS_W   = 5;
    localparam int CFG_W     = 2;

    typedef enum logic [2:0] {
        SRCH_IDLE,
        SRCH_SETUP,
        SRCH_CLEAR,
        SRCH_INIT,
        SRCH_STEP,
        SRCH_CHECK,
        SRCH_BACK,
        SRCH_DONE
    } srch_state_t;

    typedef enum logic [2:0] {
        CTRL_IDLE,
        CTRL_RUN,
        CTRL_WAIT,
        CTRL_MUL,
        CTRL_ACC,
        CTRL_OUT
    } ctrl_state_t;

endpackage

// ===== src/sawc_grid_ram.sv =====
`timescale 1ns / 1ps
module sawc_grid_ram #(
    parameter int DEPTH  = 1089,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 7
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/sawc_search.sv =====
`timescale 1ns / 1ps
module sawc_search #(
    parameter int MAX_STEPS = sawc_pkg::MAX_STEPS,
    parameter int MAX_DIM   = sawc_pkg::MAX_DIM,
    localparam int LW       = $clog2(MAX_STEPS + 1),
    localparam int KW       = $clog2(MAX_DIM + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [LW-1:0]                steps,
    input  logic [KW-1:0]                dims,
    output logic                         done,
    output logic [sawc_pkg::COUNT_W-1:0] count
);

    localparam int SIDE  = 2 * MAX_STEPS + 1;
    localparam int DEPTH = SIDE ** MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 1;
    localparam int DW    = $clog2(2 * MAX_DIM + 1);
    localparam int CW    = 2 * DW + 1;

    sawc_pkg::srch_state_t st_reg, st_next;

    logic [KW-1:0]  j_reg, j_next;
    logic [PW-1:0]  size_reg, size_next;
    logic [PW-1:0]  origin_reg, origin_next;
    logic [PW-1:0]  stride_reg [MAX_DIM];
    logic [PW-1:0]  stride_next [MAX_DIM];
    logic [PW-1:0]  clr_reg, clr_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  tgt_reg, tgt_next;
    logic [DW-1:0]  from_reg, from_next;
    logic [DW-1:0]  nx_reg, nx_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [KW-1:0]  ent_reg, ent_next;
    logic [LW-1:0]  last_reg, last_next;
    logic [LW-1:0]  marks_reg [MAX_DIM];
    logic [LW-1:0]  marks_next [MAX_DIM];
    logic [sawc_pkg::COUNT_W-1:0] count_reg, count_next;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [CW-1:0]  wr_data;
    logic [AW-1:0]  rd_addr;
    logic [CW-1:0]  rd_data;

    logic [DW-1:0]  two_k;
    logic           at_end;
    logic [DW-1:0]  dir;
    logic           plus;
    logic [PW-1:0]  sel_s;
    logic [PW-1:0]  sum;
    logic           in_range;
    logic [PW-1:0]  nb;
    logic [LW:0]    side;
    logic [KW-1:0]  ent_new;
    logic [LW-1:0]  back_len;

    sawc_grid_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (CW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign two_k  = DW'({dims, 1'b0});
    assign at_end = (nx_reg == two_k);
    assign dir    = at_end ? from_reg : nx_reg;
    assign plus   = at_end ? ~dir[0] : dir[0];
    assign side   = (LW + 1)'({steps, 1'b1});
    assign sum    = PW'(head_reg) + sel_s;
    assign back_len = len_reg - 1'b1;

    always_comb begin
        sel_s = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            if (DW'(i) == DW'(dir >> 1)) begin
                sel_s = stride_reg[i];
            end
        end
    end

    always_comb begin
        if (plus) begin
            in_range = (sum < size_reg);
            nb       = sum;
        end else begin
            in_range = (sel_s <= PW'(head_reg));
            nb       = PW'(head_reg) - sel_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= sawc_pkg::SRCH_IDLE;
        end else begin
            st_reg <= st_next;
        end
        j_reg      <= j_next;
        size_reg   <= size_next;
        origin_reg <= origin_next;
        clr_reg    <= clr_next;
        head_reg   <= head_next;
        tgt_reg    <= tgt_next;
        from_reg   <= from_next;
        nx_reg     <= nx_next;
        len_reg    <= len_next;
        ent_reg    <= ent_next;
        last_reg   <= last_next;
        count_reg  <= count_next;
        for (int i = 0; i < MAX_DIM; i++) begin
            stride_reg[i] <= stride_next[i];
            marks_reg[i]  <= marks_next[i];
        end
    end

    always_comb begin
        st_next     = st_reg;
        j_next      = j_reg;
        size_next   = size_reg;
        origin_next = origin_reg;
        clr_next    = clr_reg;
        head_next   = head_reg;
        tgt_next    = tgt_reg;
        from_next   = from_reg;
        nx_next     = nx_reg;
        len_next    = len_reg;
        ent_next    = ent_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        for (int i = 0; i < MAX_DIM; i++) begin
            stride_next[i] = stride_reg[i];
            marks_next[i]  = marks_reg[i];
        end
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = {1'b0, from_reg, nx_reg + 1'b1};
        rd_addr = tgt_reg;
        ent_new = ent_reg;
        done    = 1'b0;

        case (st_reg)
            sawc_pkg::SRCH_IDLE: begin
                if (start) begin
                    j_next      = '0;
                    size_next   = PW'(1);
                    origin_next = '0;
                    st_next     = sawc_pkg::SRCH_SETUP;
                end
            end
            sawc_pkg::SRCH_SETUP: begin
                if (j_reg == dims) begin
                    clr_next = '0;
                    st_next  = sawc_pkg::SRCH_CLEAR;
                end else begin
                    for (int i = 0; i < MAX_DIM; i++) begin
                        if (KW'(i) == j_reg) begin
                            stride_next[i] = size_reg;
                        end
                    end
                    origin_next = origin_reg + PW'(steps * size_reg);
                    size_next   = PW'(size_reg * side);
                    j_next      = j_reg + 1'b1;
                end
            end
            sawc_pkg::SRCH_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg[AW-1:0];
                wr_data  = {1'b1, {(2 * DW){1'b0}}};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == size_reg - 1'b1) begin
                    st_next = sawc_pkg::SRCH_INIT;
                end
            end
            sawc_pkg::SRCH_INIT: begin
                head_next     = origin_reg[AW-1:0];
                from_next     = '0;
                nx_next       = two_k - 1'b1;
                wr_en         = 1'b1;
                wr_addr       = origin_reg[AW-1:0];
                wr_data       = {1'b0, {DW{1'b0}}, two_k - 1'b1};
                ent_next      = '0;
                last_next     = '0;
                marks_next[0] = '0;
                len_next      = '0;
                count_next    = '0;
                st_next       = sawc_pkg::SRCH_STEP;
            end
            sawc_pkg::SRCH_STEP: begin
                if (!at_end) begin
                    if (!in_range) begin
                        wr_en   = 1'b1;
                        nx_next = nx_reg + 1'b1;
                    end else begin
                        rd_addr  = nb[AW-1:0];
                        tgt_next = nb[AW-1:0];
                        st_next  = sawc_pkg::SRCH_CHECK;
                    end
                end else if (len_reg <= LW'(1)) begin
                    st_next = sawc_pkg::SRCH_DONE;
                end else begin
                    len_next = back_len;
                    if (back_len == last_reg && ent_reg > KW'(1)) begin
                        ent_next = ent_reg - 1'b1;
                        for (int i = 0; i < MAX_DIM; i++) begin
                            if (KW'(i) == ent_reg - KW'(2)) begin
                                last_next = marks_reg[i];
                            end
                        end
                    end
                    if (!in_range) begin
                        st_next = sawc_pkg::SRCH_DONE;
                    end else begin
                        wr_en     = 1'b1;
                        wr_data   = {1'b1, {(2 * DW){1'b0}}};
                        rd_addr   = nb[AW-1:0];
                        head_next = nb[AW-1:0];
                        st_next   = sawc_pkg::SRCH_BACK;
                    end
                end
            end
            sawc_pkg::SRCH_BACK: begin
                from_next = rd_data[2*DW-1:DW];
                nx_next   = rd_data[DW-1:0] + 1'b1;
                wr_en     = 1'b1;
                wr_data   = {1'b0, rd_data[2*DW-1:DW], rd_data[DW-1:0] + 1'b1};
                st_next   = sawc_pkg::SRCH_STEP;
            end
            sawc_pkg::SRCH_CHECK: begin
                st_next = sawc_pkg::SRCH_STEP;
                if (!rd_data[CW-1]) begin
                    wr_en   = 1'b1;
                    nx_next = nx_reg + 1'b1;
                end else if (len_reg == steps - 1'b1) begin
                    wr_en      = 1'b1;
                    nx_next    = nx_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end else begin
                    len_next = len_reg + 1'b1;
                    if (ent_reg != dims &&
                        nx_reg == DW'({dims - ent_reg, 1'b0}) - 1'b1) begin
                        last_next = len_reg;
                        for (int i = 0; i < MAX_DIM; i++) begin
                            if (KW'(i) == ent_reg) begin
                                marks_next[i] = len_reg;
                            end
                        end
                        ent_new = ent_reg + 1'b1;
                    end
                    ent_next  = ent_new;
                    from_next = nx_reg;
                    nx_next   = (ent_new != dims) ?
                                DW'({dims - ent_new, 1'b0}) - 1'b1 : '0;
                    head_next = tgt_reg;
                    wr_en     = 1'b1;
                    wr_addr   = tgt_reg;
                    wr_data   = {1'b0, nx_reg, nx_next};
                end
            end
            sawc_pkg::SRCH_DONE: begin
                done    = 1'b1;
                st_next = sawc_pkg::SRCH_IDLE;
            end
            default: begin
                st_next = sawc_pkg::SRCH_IDLE;
            end
        endcase
    end

    assign count = count_reg;

    a_check_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == sawc_pkg::SRCH_CHECK |-> $past(st_reg) == sawc_pkg::SRCH_STEP)
        else $error("check without a preceding step");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == sawc_pkg::SRCH_STEP || st_reg == sawc_pkg::SRCH_CHECK)
        |-> len_reg < steps)
        else $error("walk longer than requested");

    a_dims_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == sawc_pkg::SRCH_STEP |-> ent_reg <= dims)
        else $error("more dimensions entered than in use");

endmodule

// ===== src/self_avoiding_walk_counter.sv =====
`timescale 1ns / 1ps
// Counts self-avoiding walks of s_walk_steps steps (saturated to MAX_STEPS) on a lattice of
// cfg_wr_data dimensions (clamped to 1..MAX_DIM), one transaction at a time. For walks of two
// or more steps and each number of dimensions k up to the configured value, the grid memory
// ((2n+1)^k cells) is first cleared at one cell per cycle. A backtracking walk then runs over
// the grid memory, which has one write port and one read port. Each direction tried from a
// cell passes through the STEP and CHECK states, or stays in STEP when the neighbour falls
// outside the grid, and each step back passes through STEP and BACK. Zero and one steps are
// answered without running the search. The count is returned modulo 2^32.
module self_avoiding_walk_counter #(
    parameter int MAX_STEPS = sawc_pkg::MAX_STEPS,
    parameter int MAX_DIM   = sawc_pkg::MAX_DIM
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sawc_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sawc_pkg::STEPS_W-1:0]  s_walk_steps,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sawc_pkg::COUNT_W-1:0]  m_walk_count
);

    localparam int LW = $clog2(MAX_STEPS + 1);
    localparam int KW = $clog2(MAX_DIM + 1);
    localparam int WW = 3 * MAX_DIM + 1;
    localparam int CNT = sawc_pkg::COUNT_W;

    sawc_pkg::ctrl_state_t st_reg, st_next;

    logic [sawc_pkg::CFG_W-1:0] dimensions_reg;
    logic [LW-1:0]  n_reg, n_next;
    logic [KW-1:0]  d_reg, d_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [WW-1:0]  w_reg, w_next;
    logic [CNT-1:0] part_reg, part_next;
    logic [CNT-1:0] prev_reg, prev_next;
    logic [CNT-1:0] prod_reg, prod_next;
    logic [CNT-1:0] total_reg, total_next;
    logic           m_valid_reg, m_valid_next;
    logic [CNT-1:0] m_data_reg, m_data_next;

    logic           srch_start;
    logic           srch_done;
    logic [CNT-1:0] srch_count;
    logic [LW-1:0]  n_sat;
    logic [KW-1:0]  d_clamp;

    sawc_search #(
        .MAX_STEPS (MAX_STEPS),
        .MAX_DIM   (MAX_DIM)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (srch_start),
        .steps   (n_reg),
        .dims    (k_reg),
        .done    (srch_done),
        .count   (srch_count)
    );

    always_comb begin
        if (32'(s_walk_steps) > 32'(MAX_STEPS)) begin
            n_sat = LW'(MAX_STEPS);
        end else begin
            n_sat = LW'(s_walk_steps);
        end
        if (dimensions_reg == '0) begin
            d_clamp = KW'(1);
        end else if (32'(dimensions_reg) > 32'(MAX_DIM)) begin
            d_clamp = KW'(MAX_DIM);
        end else begin
            d_clamp = KW'(dimensions_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= sawc_pkg::CTRL_IDLE;
            dimensions_reg <= sawc_pkg::CFG_W'(2);
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                dimensions_reg <= cfg_wr_data;
            end
        end
        n_reg      <= n_next;
        d_reg      <= d_next;
        k_reg      <= k_next;
        w_reg      <= w_next;
        part_reg   <= part_next;
        prev_reg   <= prev_next;
        prod_reg   <= prod_next;
        total_reg  <= total_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        st_next      = st_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        w_next       = w_reg;
        part_next    = part_reg;
        prev_next    = prev_reg;
        prod_next    = prod_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        srch_start   = 1'b0;
        s_ready      = 1'b0;

        case (st_reg)
            sawc_pkg::CTRL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    n_next     = n_sat;
                    d_next     = d_clamp;
                    k_next     = KW'(1);
                    prev_next  = '0;
                    total_next = '0;
                    w_next     = WW'({d_clamp, 1'b0});
                    if (n_sat == '0) begin
                        total_next = CNT'(1);
                        st_next    = sawc_pkg::CTRL_OUT;
                    end else begin
                        st_next = sawc_pkg::CTRL_RUN;
                    end
                end
            end
            sawc_pkg::CTRL_RUN: begin
                if (n_reg == LW'(1)) begin
                    part_next = CNT'(1);
                    st_next   = sawc_pkg::CTRL_MUL;
                end else begin
                    srch_start = 1'b1;
                    st_next    = sawc_pkg::CTRL_WAIT;
                end
            end
            sawc_pkg::CTRL_WAIT: begin
                if (srch_done) begin
                    part_next = srch_count;
                    st_next   = sawc_pkg::CTRL_MUL;
                end
            end
            sawc_pkg::CTRL_MUL: begin
                prod_next = CNT'((part_reg - prev_reg) * CNT'(w_reg));
                prev_next = part_reg;
                st_next   = sawc_pkg::CTRL_ACC;
            end
            sawc_pkg::CTRL_ACC: begin
                total_next = total_reg + prod_reg;
                if (k_reg == d_reg) begin
                    st_next = sawc_pkg::CTRL_OUT;
                end else begin
                    w_next  = WW'({w_reg * (d_reg - k_reg), 1'b0});
                    k_next  = k_reg + 1'b1;
                    st_next = sawc_pkg::CTRL_RUN;
                end
            end
            sawc_pkg::CTRL_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = total_reg;
                    st_next      = sawc_pkg::CTRL_IDLE;
                end
            end
            default: begin
                st_next = sawc_pkg::CTRL_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_walk_count = m_data_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> st_reg != sawc_pkg::CTRL_IDLE)
        else $error("transaction accepted but control stayed idle");

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == sawc_pkg::CTRL_RUN || st_reg == sawc_pkg::CTRL_WAIT)
        |-> (k_reg >= KW'(1) && k_reg <= d_reg))
        else $error("dimension index out of range");

    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        srch_done |-> st_reg == sawc_pkg::CTRL_WAIT)
        else $error("search finished while not awaited");

endmodule
